### hw/rtl/tscc_pkg.sv
// Shared types and constants for the transport-stream continuity counter checker.
`default_nettype none
package tscc_pkg;

	localparam int PID_W       = 13;
	localparam int CC_W        = 4;
	localparam int AFC_W       = 2;
	localparam int TABLE_DEPTH = 1 << PID_W;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [PID_W-1:0] NULL_PID = 13'h1FFF;

	typedef enum logic [AFC_W-1:0] {
		AFC_RESERVED = 2'd0,
		AFC_PAYLOAD  = 2'd1,
		AFC_ADAPT    = 2'd2,
		AFC_BOTH     = 2'd3
	} afc_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} back_state_t;

	typedef struct packed {
		logic             is_null;
		logic [PID_W-1:0] pid;
		logic [CC_W-1:0]  cc;
		logic [AFC_W-1:0] mode;
		logic             disc;
	} item_t;

	typedef struct packed {
		logic            seen;
		logic [CC_W-1:0] cc;
		logic            dup;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic full;
		logic nonempty;
	} queue_status_t;

endpackage
`default_nettype wire

### hw/rtl/tscc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tscc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

### hw/rtl/tscc_front.sv
// Input stage: takes packet headers, tags the null PID and feeds the queue.
`default_nettype none
module tscc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [tscc_pkg::PID_W-1:0]    packet_id,
	input  logic [tscc_pkg::CC_W-1:0]     counter,
	input  logic [tscc_pkg::AFC_W-1:0]    adapt_mode,
	input  logic                          discontinuity,
	input  logic                          clearing,
	input  tscc_pkg::queue_status_t       q_status,
	output logic                          push,
	output tscc_pkg::item_t               push_item
);
	import tscc_pkg::*;

	logic  vld_s1;
	item_t item_s1;
	logic  accept;

	assign in_stall  = clearing | (vld_s1 & q_status.full);
	assign accept    = in_valid & ~in_stall;
	assign push      = vld_s1 & ~q_status.full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.is_null <= (packet_id == NULL_PID);
			item_s1.pid     <= packet_id;
			item_s1.cc      <= counter;
			item_s1.mode    <= adapt_mode;
			item_s1.disc    <= discontinuity;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/tscc_queue.sv
// Short FIFO of classified headers between the front and back parts.
`default_nettype none
module tscc_queue #(
	parameter int QUEUE_DEPTH = tscc_pkg::QUEUE_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  tscc_pkg::item_t         push_item,
	input  logic                    pop,
	output tscc_pkg::item_t         pop_item,
	output tscc_pkg::queue_status_t q_status
);
	import tscc_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign pop_item          = mem_q[rd_ptr_q];
	assign q_status.full     = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign q_status.nonempty = (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/tscc_back.sv
// Back part: PID table clear, read-modify-write per header, result register.
`default_nettype none
module tscc_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tscc_pkg::queue_status_t    q_status,
	input  tscc_pkg::item_t            pop_item,
	output logic                       pop,
	output logic                       clearing,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       cc_error,
	output logic [tscc_pkg::CC_W-1:0]  expected_cc,
	output logic                       forward,
	output logic                       first_seen
);
	import tscc_pkg::*;

	back_state_t       state_q, state_d;
	logic [PID_W-1:0]  clr_cnt_q;
	item_t             cur_q;
	logic              out_valid_q;
	logic              cc_error_q;
	logic [CC_W-1:0]   expected_q;
	logic              forward_q;
	logic              first_q;

	logic              slot_free;
	logic              rd_en;
	logic              wr_en;
	logic [PID_W-1:0]  wr_addr;
	entry_t            wr_ent;
	logic [ENTRY_W-1:0] rd_data;
	entry_t            ent;
	logic              load;
	logic              res_err;
	logic [CC_W-1:0]   res_exp;
	logic              res_fwd;
	logic              res_first;
	logic [CC_W-1:0]   want;
	logic              new_dup;

	assign slot_free = ~out_valid_q | ~out_stall;
	assign ent       = entry_t'(rd_data);

	tscc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_ent),
		.rd_en   (rd_en),
		.rd_addr (pop_item.pid),
		.rd_data (rd_data)
	);

	// expected counter for a PID already in the table
	always_comb begin
		want    = ent.cc;
		new_dup = 1'b0;
		case (cur_q.mode)
			AFC_RESERVED: begin
				want = ent.cc;
			end
			AFC_ADAPT: begin
				want = cur_q.disc ? cur_q.cc : ent.cc;
			end
			AFC_PAYLOAD, AFC_BOTH: begin
				if (cur_q.mode == AFC_BOTH && cur_q.disc) begin
					want = cur_q.cc;
				end else if (cur_q.cc == ent.cc && !ent.dup) begin
					want    = ent.cc;
					new_dup = 1'b1;
				end else begin
					want = ent.cc + CC_W'(1);
				end
			end
			default: begin
				want = ent.cc;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == PID_W'(TABLE_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (q_status.nonempty && slot_free && !pop_item.is_null) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		clearing  = 1'b0;
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = cur_q.pid;
		wr_ent    = '{seen: 1'b1, cc: cur_q.cc, dup: 1'b0};
		load      = 1'b0;
		res_err   = 1'b0;
		res_exp   = '0;
		res_fwd   = 1'b0;
		res_first = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				clearing = 1'b1;
				wr_en    = 1'b1;
				wr_addr  = clr_cnt_q;
				wr_ent   = '0;
			end
			ST_IDLE: begin
				if (q_status.nonempty && slot_free) begin
					pop = 1'b1;
					if (pop_item.is_null) begin
						load = 1'b1;
					end else begin
						rd_en = 1'b1;
					end
				end
			end
			ST_LOOKUP: begin
				wr_en   = 1'b1;
				load    = 1'b1;
				res_fwd = 1'b1;
				if (!ent.seen) begin
					res_exp   = cur_q.cc;
					res_first = 1'b1;
				end else begin
					wr_ent.dup = new_dup;
					res_exp    = want;
					res_err    = (want != cur_q.cc);
				end
			end
			default: begin
				clearing = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + PID_W'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_item;
		end
		if (load) begin
			cc_error_q <= res_err;
			expected_q <= res_exp;
			forward_q  <= res_fwd;
			first_q    <= res_first;
		end
	end

	assign out_valid   = out_valid_q;
	assign cc_error    = cc_error_q;
	assign expected_cc = expected_q;
	assign forward     = forward_q;
	assign first_seen  = first_q;

endmodule
`default_nettype wire

### hw/rtl/ts_continuity_counter_checker.sv
// Top level of the transport-stream continuity counter checker.
// One input transfer carries the header fields of one transport packet (PID,
// continuity counter, adaptation field control, discontinuity indicator);
// exactly one result transfer follows for each, in order. Both channels use
// valid/stall; a transfer happens when valid is high and stall is low.
// A front register takes headers and tags the null PID, a short queue buffers
// them, and the back part does a read-modify-write of the 8192-entry PID table.
// A table lookup takes a RAM read step and an update step, and the back part
// takes no new header until the update is written; a null PID skips the table
// and goes at one header per cycle while the receiver does not stall. After
// reset the table is swept to zero, one entry per cycle, with in_stall high.
// When the receiver stalls, the result register holds, then the queue fills
// and in_stall rises toward the sender.
`default_nettype none
module ts_continuity_counter_checker #(
	parameter int QUEUE_DEPTH = tscc_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [tscc_pkg::PID_W-1:0] packet_id,
	input  logic [tscc_pkg::CC_W-1:0]  counter,
	input  logic [tscc_pkg::AFC_W-1:0] adapt_mode,
	input  logic                       discontinuity,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       cc_error,
	output logic [tscc_pkg::CC_W-1:0]  expected_cc,
	output logic                       forward,
	output logic                       first_seen
);
	import tscc_pkg::*;

	queue_status_t q_status;
	item_t         push_item;
	item_t         pop_item;
	logic          push;
	logic          pop;
	logic          clearing;

	tscc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.packet_id     (packet_id),
		.counter       (counter),
		.adapt_mode    (adapt_mode),
		.discontinuity (discontinuity),
		.clearing      (clearing),
		.q_status      (q_status),
		.push          (push),
		.push_item     (push_item)
	);

	tscc_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.q_status  (q_status)
	);

	tscc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_status    (q_status),
		.pop_item    (pop_item),
		.pop         (pop),
		.clearing    (clearing),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cc_error    (cc_error),
		.expected_cc (expected_cc),
		.forward     (forward),
		.first_seen  (first_seen)
	);

endmodule
`default_nettype wire
